// ===== hw/rtl/lpl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lpl_pkg;

	localparam int SAMPLE_BITS  = 24;
	localparam int MAX_CHANNELS = 2;

	localparam int GAIN_W     = 24;
	localparam int DRIVE_FRAC = 20;
	localparam int ACT_W      = 2;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 24;

	// |s| * d, and that times a Q1.23 gain
	localparam int P_W    = SAMPLE_BITS + GAIN_W;
	localparam int PROD_W = P_W + GAIN_W;

	// digit-serial multiplier: 8-bit digits of the second operand
	localparam int DIGIT_W   = 8;
	localparam int MUL_STEPS = GAIN_W / DIGIT_W;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);

	// restoring divider: one quotient bit per cycle
	localparam int Q_W       = GAIN_W - 1;
	localparam int DIV_CNT_W = $clog2(Q_W);

	localparam int LIM_SHIFT = SAMPLE_BITS - 1 + DRIVE_FRAC - (GAIN_W - 1);
	localparam int OUT_SHIFT = DRIVE_FRAC + GAIN_W - 1;
	localparam int R_W       = PROD_W - OUT_SHIFT;

	localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_W = ((2 * SAMPLE_BITS + GAIN_W + 7) / 8) * 8;

	localparam logic [GAIN_W-1:0] UNITY_Q23     = GAIN_W'(8388608);
	localparam logic [GAIN_W-1:0] DRIVE_RST     = GAIN_W'(1048576);
	localparam logic [GAIN_W-1:0] RELEASE_RST   = GAIN_W'(16442298);
	localparam logic [ACT_W-1:0]  ACTIVE_RST    = ACT_W'(2);
	localparam logic [ACT_W-1:0]  ACTIVE_BYPASS = ACT_W'(0);
	localparam logic [ACT_W-1:0]  ACTIVE_STEREO = ACT_W'(2);

	localparam logic [PROD_W-1:0]      RND_BIAS = PROD_W'(1) << (OUT_SHIFT - 1);
	localparam logic [R_W-1:0]         SMP_LIM  = R_W'(1) << (SAMPLE_BITS - 1);

	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_CEILING = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = CFG_IDX_W'(3);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_P0,
		ST_MUL_P1,
		ST_CMP,
		ST_DIV,
		ST_GAIN,
		ST_MUL_REL,
		ST_OUT_L,
		ST_OUT_R,
		ST_DONE
	} lpl_state_t;

	// round half away from zero on the magnitude, then saturate
	function automatic logic [SAMPLE_BITS-1:0] sat_out(input logic [PROD_W-1:0] prod,
			input logic neg);
		logic [PROD_W-1:0] sum;
		logic [R_W-1:0]    r;
		logic [SAMPLE_BITS-1:0] res;
		sum = prod + RND_BIAS;
		r   = sum[PROD_W-1:OUT_SHIFT];
		if (neg) begin
			if (r > SMP_LIM)
				r = SMP_LIM;
			res = SAMPLE_BITS'(0) - r[SAMPLE_BITS-1:0];
		end else begin
			if (r > SMP_LIM - R_W'(1))
				r = SMP_LIM - R_W'(1);
			res = r[SAMPLE_BITS-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/linked_peak_limiter_core.sv =====
// Channel  Dir  Handshake             Payload
// s_axis   in   s_axis_tvalid/tready  sample_left, sample_right
// m_axis   out  m_axis_tvalid/tready  out_left, out_right, gain_now
// cfg      in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One frame at a time; a bypass frame skips the multiply and divide states.
// Each product runs on the shared 8-bit-digit multiplier; a limiting
// frame also passes through the one-bit-per-cycle restoring divider.
// A new frame is taken while the previous result waits in the output register.
// Reset restores register defaults and unity gain; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module linked_peak_limiter_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [23:0] sample_left, [47:24] sample_right
	input  wire logic [lpl_pkg::IN_W-1:0]        s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// [23:0] out_left, [47:24] out_right, [71:48] gain_now
	output logic [lpl_pkg::OUT_W-1:0]            m_axis_tdata,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [lpl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [lpl_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lpl_pkg::*;

	lpl_state_t state_q, state_d;

	logic [GAIN_W-1:0] drive_q, ceil_q, rel_q;
	logic [ACT_W-1:0]  act_q;
	logic [GAIN_W-1:0] g_q;
	logic              stereo_q, bypass_q, out_valid_q;

	logic                   neg0_q, neg1_q;
	logic [SAMPLE_BITS-1:0] mag0_q, mag1_q;
	logic [P_W-1:0]         p0_q, p1_q;
	logic [GAIN_W-1:0]      t_q, diff_q;
	logic [SAMPLE_BITS-1:0] ol_q, or_q;
	logic [SAMPLE_BITS-1:0] ol_o_q, or_o_q;
	logic [GAIN_W-1:0]      gain_o_q;

	logic                   in_fire, out_load;
	logic                   bypass_in, stereo_in;
	logic [SAMPLE_BITS-1:0] s0, s1;
	logic [P_W-1:0]         peak, limit;
	logic                   over, attack;

	logic                mul_start, mul_busy, mul_done;
	logic [P_W-1:0]      mul_a;
	logic [GAIN_W-1:0]   mul_b;
	logic [PROD_W-1:0]   mul_prod;
	logic                div_start, div_done;
	logic [Q_W-1:0]      div_quo;

	assign s0        = s_axis_tdata[SAMPLE_BITS-1:0];
	assign s1        = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign bypass_in = act_q == ACTIVE_BYPASS;
	assign stereo_in = (MAX_CHANNELS >= 2) && (act_q >= ACTIVE_STEREO);
	assign peak      = (p0_q > p1_q) ? p0_q : p1_q;
	assign limit     = P_W'(ceil_q) << LIM_SHIFT;
	assign over      = peak > limit;
	assign attack    = t_q < g_q;
	assign cfg_ready = 1'b1;

	lpl_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.busy    (mul_busy),
		.done    (mul_done),
		.product (mul_prod)
	);

	lpl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (limit),
		.divisor  (peak),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire)
					state_d = bypass_in ? ST_DONE : ST_MUL_P0;
			end
			ST_MUL_P0: begin
				if (mul_done)
					state_d = stereo_q ? ST_MUL_P1 : ST_CMP;
			end
			ST_MUL_P1: begin
				if (mul_done)
					state_d = ST_CMP;
			end
			ST_CMP:     state_d = over ? ST_DIV : ST_GAIN;
			ST_DIV: begin
				if (div_done)
					state_d = ST_GAIN;
			end
			ST_GAIN:    state_d = attack ? ST_OUT_L : ST_MUL_REL;
			ST_MUL_REL: begin
				if (mul_done)
					state_d = ST_OUT_L;
			end
			ST_OUT_L: begin
				if (mul_done)
					state_d = stereo_q ? ST_OUT_R : ST_DONE;
			end
			ST_OUT_R: begin
				if (mul_done)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || m_axis_tready)
					state_d = ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = state_q == ST_IDLE;
		div_start     = (state_q == ST_CMP) && over;
		out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
		mul_start     = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		unique case (state_q)
			ST_MUL_P0: begin
				mul_a = P_W'(mag0_q);
				mul_b = drive_q;
			end
			ST_MUL_P1: begin
				mul_a = P_W'(mag1_q);
				mul_b = drive_q;
			end
			ST_MUL_REL: begin
				mul_a = P_W'(diff_q);
				mul_b = rel_q;
			end
			ST_OUT_L: begin
				mul_a = p0_q;
				mul_b = g_q;
			end
			ST_OUT_R: begin
				mul_a = p1_q;
				mul_b = g_q;
			end
			default: begin
			end
		endcase
		if (state_q == ST_MUL_P0 || state_q == ST_MUL_P1 || state_q == ST_MUL_REL ||
				state_q == ST_OUT_L || state_q == ST_OUT_R)
			mul_start = !mul_busy && !mul_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			drive_q     <= DRIVE_RST;
			ceil_q      <= UNITY_Q23;
			rel_q       <= RELEASE_RST;
			act_q       <= ACTIVE_RST;
			g_q         <= UNITY_Q23;
			stereo_q    <= 1'b0;
			bypass_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_DRIVE:   drive_q <= cfg_data;
					CFG_CEILING: ceil_q  <= cfg_data;
					CFG_RELEASE: rel_q   <= cfg_data;
					CFG_ACTIVE:  act_q   <= cfg_data[ACT_W-1:0];
					default: begin
					end
				endcase
			end
			if (in_fire) begin
				stereo_q <= stereo_in;
				bypass_q <= bypass_in;
			end
			if (state_q == ST_GAIN && attack)
				g_q <= t_q;
			if (state_q == ST_MUL_REL && mul_done)
				g_q <= t_q - mul_prod[2*GAIN_W-1:GAIN_W];
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			neg0_q <= s0[SAMPLE_BITS-1];
			neg1_q <= s1[SAMPLE_BITS-1];
			mag0_q <= s0[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - s0) : s0;
			mag1_q <= s1[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - s1) : s1;
			p1_q   <= '0;
			if (bypass_in) begin
				ol_q <= s0;
				or_q <= s1;
			end else if (!stereo_in) begin
				or_q <= '0;
			end
		end
		if (mul_done) begin
			unique case (state_q)
				ST_MUL_P0: p0_q <= mul_prod[P_W-1:0];
				ST_MUL_P1: p1_q <= mul_prod[P_W-1:0];
				ST_OUT_L:  ol_q <= sat_out(mul_prod, neg0_q);
				ST_OUT_R:  or_q <= sat_out(mul_prod, neg1_q);
				default: begin
				end
			endcase
		end
		if (state_q == ST_CMP && !over)
			t_q <= UNITY_Q23;
		if (state_q == ST_DIV && div_done)
			t_q <= GAIN_W'(div_quo);
		if (state_q == ST_GAIN)
			diff_q <= t_q - g_q;
		if (out_load) begin
			ol_o_q   <= ol_q;
			or_o_q   <= or_q;
			gain_o_q <= g_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({gain_o_q, or_o_q, ol_o_q});

	a_gain_le_unity: assert property (@(posedge clk) disable iff (!arst_n)
		g_q <= UNITY_Q23)
		else $error("gain above unity");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside divide state");

	a_mul_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_MUL_P0 || state_q == ST_MUL_P1 ||
			state_q == ST_MUL_REL || state_q == ST_OUT_L || state_q == ST_OUT_R))
		else $error("multiplier finished outside multiply state");

	a_mono_right_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !stereo_q && !bypass_q) |-> (or_q == '0))
		else $error("right channel not zero in mono");

endmodule

`default_nettype wire

// ===== hw/rtl/lpl_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpl_mul (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [lpl_pkg::P_W-1:0]     a,
	input  wire logic [lpl_pkg::GAIN_W-1:0]  b,
	output logic                             busy,
	output logic                             done,
	output logic [lpl_pkg::PROD_W-1:0]       product
);
	import lpl_pkg::*;

	logic [PROD_W-1:0]    a_q;
	logic [PROD_W-1:0]    acc_q;
	logic [GAIN_W-1:0]    b_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + MUL_CNT_W'(1);
				if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one digit of b per cycle, LSB digit first
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= PROD_W'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + a_q * PROD_W'(b_q[DIGIT_W-1:0]);
			a_q   <= a_q << DIGIT_W;
			b_q   <= b_q >> DIGIT_W;
		end
	end

	assign busy    = busy_q;
	assign done    = done_q;
	assign product = acc_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (!busy_q && !done_q))
		else $error("multiplier started while busy");

endmodule

`default_nettype wire

// ===== hw/rtl/lpl_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpl_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [lpl_pkg::P_W-1:0]  dividend,
	input  wire logic [lpl_pkg::P_W-1:0]  divisor,
	output logic                          done,
	output logic [lpl_pkg::Q_W-1:0]       quotient
);
	import lpl_pkg::*;

	logic [P_W-1:0]       rem_q;
	logic [P_W-1:0]       dvs_q;
	logic [Q_W-1:0]       quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [P_W:0]         rem_sh;
	logic                 ge;

	assign rem_sh = {rem_q, 1'b0};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder stays below the divisor, so it always fits in P_W bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? P_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[P_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire
